FILE: hw/rtl/skc_pkg.sv
`default_nettype none

package skc_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int LEVEL_FRAC_BITS = 8;
    localparam int LEVEL_BITS      = 16;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int MUL_W           = 34;
    localparam int PROD_W          = 2 * MUL_W;

    localparam int DB_PER_LOG2 = 394566;
    localparam int LOG2_PER_DB = 10885;
    localparam int LEVEL_FLOOR = ((120 << LEVEL_FRAC_BITS) > 32768) ? -32768
                                 : -(120 << LEVEL_FRAC_BITS);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD   = 4'd0,
        CFG_INV_RATIO   = 4'd1,
        CFG_KNEE_WIDTH  = 4'd2,
        CFG_KNEE_COEFF  = 4'd3,
        CFG_MAKEUP      = 4'd4,
        CFG_AUTO_MAKEUP = 4'd5,
        CFG_ATTACK      = 4'd6,
        CFG_RELEASE     = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_start;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic signed [LEVEL_BITS-1:0]  applied_reduction;
        logic signed [LEVEL_BITS-1:0]  peak_reduction;
    } out_t;

    // log2(1+m), q16
    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^f, q16
    function automatic logic [17:0] exp2_tab(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/skc_mul.sv
`default_nettype none

module skc_mul
    import skc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/soft_knee_compressor_top.sv
// the 32-bit magnitude is normalized by a one-bit shift loop, one shift per leading
// zero (8 to 31 at 24-bit samples), then log converted; a zero sample skips both steps
// the knee path runs once, and auto makeup adds a second knee pass; a new sample is
// taken only once the last result is loaded for output, so an output stall holds the
// input; the one-bit normalize loop and the single shared 34x34 multiplier pace the work
// reset: asynchronous, active low; registers take their defaults, envelope at floor
`default_nettype none

module soft_knee_compressor_top
    import skc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_t                       in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output out_t                           out_data,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB         = SAMPLE_BITS;
    localparam int LOG_SHIFT  = 32 - LEVEL_FRAC_BITS;
    localparam int KNEE_SHIFT = 18 + LEVEL_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] KN_RND = PROD_W'(1) <<< (KNEE_SHIFT - 1);
    localparam logic [95:0] LIM = 96'(1) << (SB - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LOG1, S_LOG2, S_LOG3, S_ENV1, S_ENV2,
        S_KN1, S_KN_SQ, S_KN_IN, S_KN_OV, S_EXP1, S_EXP2, S_EXP3, S_EXP4, S_WAIT
    } state_t;

    // configuration
    logic signed [15:0] thr_reg;
    logic [16:0]        inv_reg;
    logic [14:0]        knee_reg;
    logic signed [23:0] kcoef_reg;
    logic signed [14:0] makeup_lvl_reg;
    logic               auto_reg;
    logic [15:0]        att_reg;
    logic [15:0]        rel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= -16'sd4608;
            inv_reg        <= 17'd21845;
            knee_reg       <= 15'd1536;
            kcoef_reg      <= -24'sd3641;
            makeup_lvl_reg <= '0;
            auto_reg       <= 1'b1;
            att_reg        <= 16'd65264;
            rel_reg        <= 16'd65519;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:   thr_reg        <= cfg_data[15:0];
                CFG_INV_RATIO:   inv_reg        <= cfg_data[16:0];
                CFG_KNEE_WIDTH:  knee_reg       <= cfg_data[14:0];
                CFG_KNEE_COEFF:  kcoef_reg      <= cfg_data[23:0];
                CFG_MAKEUP:      makeup_lvl_reg <= cfg_data[14:0];
                CFG_AUTO_MAKEUP: auto_reg       <= cfg_data[0];
                CFG_ATTACK:      att_reg        <= cfg_data[15:0];
                CFG_RELEASE:     rel_reg        <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // datapath state
    state_t             state_reg;
    logic               neg_reg;
    logic [SB-1:0]      mag_reg;
    logic [31:0]        norm_reg;
    logic [4:0]         p_reg;
    logic               bs_reg;
    logic               pass_reg;
    logic signed [15:0] lvl_reg;
    logic signed [15:0] env_reg;
    logic signed [15:0] peak_reg;
    logic signed [15:0] gr_reg;
    logic signed [15:0] makeup_reg;
    logic [15:0]        f_reg;
    logic signed [7:0]  n_reg;
    logic [SB-1:0]      res_reg;
    out_t               out_reg;
    logic               out_valid_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    skc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // input magnitude
    logic [SB-1:0] in_mag;
    assign in_mag = in_data.sample_in[SB-1] ? SB'(-in_data.sample_in)
                                            : SB'(in_data.sample_in);

    // log conversion
    logic [4:0]               log_idx;
    logic [11:0]              log_t;
    logic [16:0]              log_lo;
    logic [16:0]              log_hi;
    logic [16:0]              frac;
    logic signed [MUL_W-1:0]  l_val;
    logic signed [PROD_W-1:0] lvl_wide;
    logic signed [15:0]       lvl_clamp;

    assign log_idx  = {1'b0, norm_reg[30:27]};
    assign log_t    = norm_reg[26:15];
    assign log_lo   = log2_tab(log_idx);
    assign log_hi   = log2_tab(log_idx + 5'd1);
    assign frac     = log_lo + 17'(prod[24:12]);
    assign l_val    = ((MUL_W'($signed({1'b0, p_reg})) - MUL_W'(SB - 1)) <<< 16)
                      + MUL_W'(frac);
    assign lvl_wide = prod >>> LOG_SHIFT;
    assign lvl_clamp = (lvl_wide < PROD_W'(LEVEL_FLOOR)) ? 16'(LEVEL_FLOOR)
                     : (lvl_wide > 0) ? 16'sd0 : lvl_wide[15:0];

    // envelope
    logic [15:0]              env_c;
    logic [16:0]              env_fac;
    logic signed [17:0]       env_diff;
    logic signed [PROD_W-1:0] env_sum;
    logic signed [15:0]       env_clamp;

    assign env_c     = (lvl_reg > env_reg) ? att_reg : rel_reg;
    assign env_fac   = 17'd65536 - {1'b0, env_c};
    assign env_diff  = 18'(lvl_reg) - 18'(env_reg);
    assign env_sum   = PROD_W'(env_reg) + ((prod + PROD_W'(32768)) >>> 16);
    assign env_clamp = (env_sum < PROD_W'(-32768)) ? -16'sd32768
                     : (env_sum > PROD_W'(32767)) ? 16'sd32767 : env_sum[15:0];

    // knee curve
    logic signed [15:0]       kl;
    logic signed [16:0]       kdiff;
    logic signed [17:0]       d2;
    logic signed [17:0]       knee_s;
    logic signed [17:0]       x2;
    logic [16:0]              inv_eff;
    logic [16:0]              rfac;
    logic [23:0]              acoef;
    logic signed [PROD_W-1:0] kn_mag;
    logic signed [15:0]       kn_g;
    logic signed [16:0]       kn_neg;

    assign kl      = pass_reg ? 16'sd0 : env_reg;
    assign kdiff   = 17'(kl) - 17'(thr_reg);
    assign d2      = {kdiff, 1'b0};
    assign knee_s  = $signed({3'b000, knee_reg});
    assign x2      = d2 + knee_s;
    assign inv_eff = (inv_reg > 17'd65536) ? 17'd65536 : inv_reg;
    assign rfac    = 17'd65536 - inv_eff;
    assign acoef   = kcoef_reg[23] ? 24'(-kcoef_reg) : 24'd0;

    always_comb
    begin
        case (state_reg)
            S_KN_IN: kn_mag = (prod + KN_RND) >>> KNEE_SHIFT;
            S_KN_OV: kn_mag = (prod + PROD_W'(32768)) >>> 16;
            default: kn_mag = '0;
        endcase
    end

    assign kn_g   = (kn_mag > PROD_W'(32768)) ? -16'sd32768 : 16'(-kn_mag);
    assign kn_neg = -17'(kn_g);

    // gain to linear
    logic signed [16:0]       db_sum;
    logic signed [PROD_W-1:0] e_wide;
    logic signed [PROD_W-1:0] e_int;
    logic signed [7:0]        n_clamp;
    logic [15:0]              exp_f;
    logic [4:0]               exp_idx;
    logic [17:0]              exp_lo;
    logic [17:0]              exp_hi;
    logic [17:0]              mant;

    assign db_sum  = 17'(gr_reg) + 17'(makeup_reg);
    assign e_wide  = prod >>> LEVEL_FRAC_BITS;
    assign e_int   = e_wide >>> 16;
    assign n_clamp = (e_int < PROD_W'(-64)) ? -8'sd64
                   : (e_int > PROD_W'(40)) ? 8'sd40 : e_int[7:0];
    assign exp_f   = (state_reg == S_EXP2) ? e_wide[15:0] : f_reg;
    assign exp_idx = {1'b0, exp_f[15:12]};
    assign exp_lo  = exp2_tab(exp_idx);
    assign exp_hi  = exp2_tab(exp_idx + 5'd1);
    assign mant    = exp_lo + 18'(prod[24:12]);

    // output scaling
    logic signed [7:0] s8;
    logic signed [7:0] s_neg;
    logic [6:0]        sh;
    logic [63:0]       prod64;
    logic [95:0]       up;
    logic [63:0]       dn;
    logic [95:0]       val;
    logic [95:0]       pos_mag;
    logic [95:0]       neg_mag;
    logic [SB-1:0]     res_sample;

    assign s8      = n_reg - 8'sd16;
    assign s_neg   = -s8;
    assign sh      = s_neg[6:0];
    assign prod64  = prod[63:0];
    assign up      = 96'(prod64) << s8[4:0];
    assign dn      = (sh > 7'd62) ? 64'd0 : ((prod64 + (64'd1 << (sh - 7'd1))) >> sh);
    assign val     = (s8 >= 0) ? up : 96'(dn);
    assign pos_mag = (val > LIM - 96'd1) ? LIM - 96'd1 : val;
    assign neg_mag = (val > LIM) ? LIM : val;
    assign res_sample = neg_reg ? SB'(-neg_mag) : SB'(pos_mag);

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_LOG1:
            begin
                mul_a = MUL_W'(log_hi - log_lo);
                mul_b = MUL_W'(log_t);
            end
            S_LOG2:
            begin
                mul_a = l_val;
                mul_b = MUL_W'(DB_PER_LOG2);
            end
            S_ENV1:
            begin
                mul_a = MUL_W'(env_diff);
                mul_b = MUL_W'(env_fac);
            end
            S_KN1:
            begin
                if (d2 >= knee_s)
                begin
                    mul_a = MUL_W'(kdiff);
                    mul_b = MUL_W'(rfac);
                end
                else
                begin
                    mul_a = MUL_W'(x2);
                    mul_b = MUL_W'(x2);
                end
            end
            S_KN_SQ:
            begin
                mul_a = MUL_W'(acoef);
                mul_b = prod[MUL_W-1:0];
            end
            S_EXP1:
            begin
                mul_a = MUL_W'(db_sum);
                mul_b = MUL_W'(LOG2_PER_DB);
            end
            S_EXP2:
            begin
                mul_a = MUL_W'(exp_hi - exp_lo);
                mul_b = MUL_W'(exp_f[11:0]);
            end
            S_EXP3:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mant);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    logic kn_done;
    assign kn_done = ((state_reg == S_KN1) && (d2 <= -knee_s))
                     || (state_reg == S_KN_IN) || (state_reg == S_KN_OV);

    // output register free to take the new result
    logic out_load;
    assign out_load = ((state_reg == S_EXP4) || (state_reg == S_WAIT))
                      && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            norm_reg      <= '0;
            p_reg         <= '0;
            bs_reg        <= 1'b0;
            pass_reg      <= 1'b0;
            lvl_reg       <= '0;
            env_reg       <= 16'(LEVEL_FLOOR);
            peak_reg      <= '0;
            gr_reg        <= '0;
            makeup_reg    <= '0;
            f_reg         <= '0;
            n_reg         <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_reg.sample_out        <= (state_reg == S_WAIT) ? res_reg : res_sample;
                out_reg.applied_reduction <= gr_reg;
                out_reg.peak_reduction    <= peak_reg;
                out_valid_reg             <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (kn_done)
            begin
                if (!pass_reg)
                begin
                    gr_reg <= kn_g;
                    if (kn_g < peak_reg)
                    begin
                        peak_reg <= kn_g;
                    end
                    if (auto_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_KN1;
                    end
                    else
                    begin
                        makeup_reg <= 16'(makeup_lvl_reg);
                        state_reg  <= S_EXP1;
                    end
                end
                else
                begin
                    makeup_reg <= 16'(kn_neg[16:1]);
                    state_reg  <= S_EXP1;
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            neg_reg  <= in_data.sample_in[SB-1];
                            mag_reg  <= in_mag;
                            norm_reg <= 32'(in_mag);
                            p_reg    <= 5'd31;
                            bs_reg   <= in_data.block_start;
                            lvl_reg  <= 16'(LEVEL_FLOOR);
                            state_reg <= (in_mag == '0) ? S_ENV1 : S_NORM;
                        end
                    end
                    S_NORM:
                    begin
                        if (norm_reg[31])
                        begin
                            state_reg <= S_LOG1;
                        end
                        else
                        begin
                            norm_reg <= {norm_reg[30:0], 1'b0};
                            p_reg    <= p_reg - 5'd1;
                        end
                    end
                    S_LOG1:  state_reg <= S_LOG2;
                    S_LOG2:  state_reg <= S_LOG3;
                    S_LOG3:
                    begin
                        lvl_reg   <= lvl_clamp;
                        state_reg <= S_ENV1;
                    end
                    S_ENV1:
                    begin
                        if (bs_reg)
                        begin
                            peak_reg <= '0;
                        end
                        state_reg <= S_ENV2;
                    end
                    S_ENV2:
                    begin
                        env_reg   <= env_clamp;
                        pass_reg  <= 1'b0;
                        state_reg <= S_KN1;
                    end
                    S_KN1:   state_reg <= (d2 >= knee_s) ? S_KN_OV : S_KN_SQ;
                    S_KN_SQ: state_reg <= S_KN_IN;
                    S_EXP1:  state_reg <= S_EXP2;
                    S_EXP2:
                    begin
                        f_reg     <= e_wide[15:0];
                        n_reg     <= n_clamp;
                        state_reg <= S_EXP3;
                    end
                    S_EXP3:  state_reg <= S_EXP4;
                    S_EXP4:
                    begin
                        // product is gone next cycle, keep the scaled sample
                        if (out_load)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg   <= res_sample;
                            state_reg <= S_WAIT;
                        end
                    end
                    S_WAIT:
                    begin
                        if (out_load)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/skc_checker.sv
`default_nettype none

module skc_props
    import skc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    // one request in flight at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a request");

    a_reduction_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.applied_reduction[LEVEL_BITS-1]
                       || out_data.applied_reduction == '0))
        else $error("positive gain reduction");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.peak_reduction <= out_data.applied_reduction)
        else $error("peak meter above applied reduction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind soft_knee_compressor_top skc_props u_skc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
